// ===== hdl/tssp_pkg.sv =====
// ----------------------------------------------------------------------------
// tssp_pkg
// Shared types and constants of the tab snapshot stream parser: result item
// layout, item kinds, status codes, header magic and hash constants.
// ----------------------------------------------------------------------------
package tssp_pkg;

  // Default limits of the file format.
  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam int unsigned URL_LIMIT_DEF     = 2048;
  localparam int unsigned TITLE_LIMIT_DEF   = 256;
  localparam int unsigned PAYLOAD_LIMIT_DEF = 65536;

  // Item kinds.
  localparam logic [2:0] KIND_SNAP   = 3'd0;
  localparam logic [2:0] KIND_ENTRY  = 3'd1;
  localparam logic [2:0] KIND_URL    = 3'd2;
  localparam logic [2:0] KIND_TITLE  = 3'd3;
  localparam logic [2:0] KIND_ACCEPT = 3'd4;
  localparam logic [2:0] KIND_REJECT = 3'd5;

  // Verdict status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_MAGIC    = 4'd2;
  localparam logic [3:0] ST_TOO_LONG = 4'd3;
  localparam logic [3:0] ST_TRAILING = 4'd4;
  localparam logic [3:0] ST_CHECKSUM = 4'd5;
  localparam logic [3:0] ST_COUNT    = 4'd6;
  localparam logic [3:0] ST_URL_LEN  = 4'd7;
  localparam logic [3:0] ST_TITLE_LEN = 4'd8;
  localparam logic [3:0] ST_NUL_URL  = 4'd9;
  localparam logic [3:0] ST_SCROLL   = 4'd10;
  localparam logic [3:0] ST_MISMATCH = 4'd11;

  // File magic, first byte first.
  localparam logic [7:0] MAGIC [8] = '{8'h54, 8'h46, 8'h54, 8'h41,
                                       8'h42, 8'h30, 8'h31, 8'h00};

  // FNV-1a 32-bit hash.
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Output queue depth (two results per byte at most).
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  // Packed tdata width of one result (139 bits of fields, padded to bytes).
  localparam int unsigned OUT_DATA_W = 144;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         data_byte;
    logic [3:0]         entry_number;
    logic [4:0]         snap_entries;
    logic [3:0]         current_entry;
    logic [30:0]        scroll_offset;
    logic signed [31:0] focus_type;
    logic [31:0]        focus_position;
    logic [10:0]        url_bytes;
    logic [7:0]         title_bytes;
    logic [3:0]         status;
    logic               run_last;
  } res_t;

  // Results produced for one accepted byte.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  // Output queue status.
  typedef struct packed {
    logic [Q_CW-1:0] fill;
    logic            room;
  } q_stat_t;

endpackage

// ===== hdl/tssp_decoder.sv =====
// ----------------------------------------------------------------------------
// tssp_decoder
// Parse state of the snapshot file. On every accepted byte it updates the
// header, payload and entry state and produces up to two result items.
// ----------------------------------------------------------------------------
module tssp_decoder
  import tssp_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned URL_LIMIT     = URL_LIMIT_DEF,
  parameter int unsigned TITLE_LIMIT   = TITLE_LIMIT_DEF,
  parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic [7:0] file_byte,
  input  logic     end_of_file,
  output dec_out_t dec
);

  localparam int unsigned PL_W = $clog2(PAYLOAD_LIMIT + 1);
  localparam int unsigned HD_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned UL_W = $clog2(URL_LIMIT);
  localparam int unsigned TL_W = (TITLE_LIMIT > 1) ? $clog2(TITLE_LIMIT) : 1;
  localparam int unsigned RW   = (UL_W > TL_W) ? UL_W : TL_W;
  localparam int unsigned CW0  = (PL_W > RW) ? PL_W : RW;
  localparam int unsigned CW   = CW0 + 1;

  // Parse phases.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_FIELDS  = 3'd1;
  localparam logic [2:0] PH_URL     = 3'd2;
  localparam logic [2:0] PH_TITLE   = 3'd3;
  localparam logic [2:0] PH_TAIL    = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_AFTER   = 3'd6;
  localparam logic [2:0] PH_DISCARD = 3'd7;

  logic [2:0]      phase_r, phase_nxt;
  logic [3:0]      hpos_r, hpos_nxt;
  logic [PL_W-1:0] ppos_r, ppos_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [1:0]      fcnt_r, fcnt_nxt;
  logic [31:0]     hash_r, hash_nxt;
  logic [PL_W-1:0] declared_r, declared_nxt;
  logic            len_big_r, len_big_nxt;
  logic [31:0]     expected_r, expected_nxt;
  logic [HD_W-1:0] total_r, total_nxt;
  logic            total_big_r, total_big_nxt;
  logic [HD_W-1:0] ecnt_r, ecnt_nxt;
  logic [2:0]      sel_r, sel_nxt;
  logic [RW-1:0]   remain_r, remain_nxt;
  logic [31:0]     scroll_r, scroll_nxt;
  logic [31:0]     ftype_r, ftype_nxt;
  logic [31:0]     fpos_r, fpos_nxt;
  logic [UL_W-1:0] url_r, url_nxt;
  logic            url_bad_r, url_bad_nxt;
  logic [TL_W-1:0] title_r, title_nxt;
  logic [3:0]      fe_r, fe_nxt;
  logic [3:0]      de_r, de_nxt;

  // Byte processing and result assembly.
  always_comb begin
    logic [31:0]     sv;
    logic            item_v;
    res_t            item;
    res_t            verdict;
    logic            ent_done;
    logic [PL_W-1:0] left;
    logic [CW-1:0]   left_c;
    logic [CW-1:0]   url_c;
    logic [CW-1:0]   title_c;
    logic [3:0]      st;

    phase_nxt     = phase_r;
    hpos_nxt      = hpos_r;
    ppos_nxt      = ppos_r;
    shift_nxt     = shift_r;
    fcnt_nxt      = fcnt_r;
    hash_nxt      = hash_r;
    declared_nxt  = declared_r;
    len_big_nxt   = len_big_r;
    expected_nxt  = expected_r;
    total_nxt     = total_r;
    total_big_nxt = total_big_r;
    ecnt_nxt      = ecnt_r;
    sel_nxt       = sel_r;
    remain_nxt    = remain_r;
    scroll_nxt    = scroll_r;
    ftype_nxt     = ftype_r;
    fpos_nxt      = fpos_r;
    url_nxt       = url_r;
    url_bad_nxt   = url_bad_r;
    title_nxt     = title_r;
    fe_nxt        = fe_r;
    de_nxt        = de_r;

    sv       = shift_r | (32'(file_byte) << {fcnt_r, 3'b000});
    item_v   = 1'b0;
    item     = '0;
    verdict  = '0;
    ent_done = 1'b0;
    left     = declared_r - ppos_nxt;
    left_c   = '0;
    url_c    = CW'(url_r);
    title_c  = CW'(title_r);
    st       = ST_OK;

    if (phase_r == PH_HEADER) begin
      // Header: magic, payload length, checksum.
      hpos_nxt = hpos_r + 4'd1;
      if (hpos_r[3] == 1'b0) begin
        if (file_byte != MAGIC[hpos_r[2:0]] && fe_r == ST_OK) begin
          fe_nxt = ST_MAGIC;
        end
      end else if (fcnt_r != 2'd3) begin
        shift_nxt = sv;
        fcnt_nxt  = fcnt_r + 2'd1;
      end else begin
        shift_nxt = '0;
        fcnt_nxt  = '0;
        if (hpos_r == 4'd11) begin
          declared_nxt = PL_W'(sv);
          len_big_nxt  = sv > 32'(PAYLOAD_LIMIT);
        end else begin
          expected_nxt = sv;
        end
        if (hpos_r == 4'd15) begin
          priority if (fe_r != ST_OK) begin
            phase_nxt = PH_DISCARD;
          end else if (len_big_r) begin
            fe_nxt    = ST_TOO_LONG;
            phase_nxt = PH_DISCARD;
          end else if (declared_r == '0) begin
            de_nxt    = ST_MISMATCH;
            phase_nxt = PH_AFTER;
          end else begin
            phase_nxt = PH_FIELDS;
            sel_nxt   = 3'd0;
          end
        end
      end
    end else if (phase_r == PH_AFTER) begin
      fe_nxt = ST_TRAILING;
    end else if (phase_r != PH_DISCARD) begin
      // Payload byte: hash and count it, then decode by phase.
      hash_nxt = (hash_r ^ 32'(file_byte)) * FNV_PRIME;
      ppos_nxt = ppos_r + PL_W'(1);
      left     = declared_r - ppos_nxt;
      left_c   = CW'(left);
      unique case (phase_r)
        PH_FIELDS: begin
          if (fcnt_r != 2'd3) begin
            shift_nxt = sv;
            fcnt_nxt  = fcnt_r + 2'd1;
          end else begin
            shift_nxt = '0;
            fcnt_nxt  = '0;
            unique case (sel_r)
              3'd0: begin
                total_nxt     = HD_W'(sv);
                total_big_nxt = sv > 32'(HISTORY_DEPTH);
                sel_nxt       = 3'd1;
              end
              3'd1: begin
                if (total_r == '0 || total_big_r || sv >= 32'(total_r)) begin
                  de_nxt    = ST_COUNT;
                  phase_nxt = PH_SKIP;
                end else begin
                  ecnt_nxt           = '0;
                  item_v             = 1'b1;
                  item.kind          = KIND_SNAP;
                  item.snap_entries  = 5'(total_r);
                  item.current_entry = 4'(sv);
                  sel_nxt            = 3'd2;
                end
              end
              3'd2: begin
                scroll_nxt = sv;
                sel_nxt    = 3'd3;
              end
              3'd3: begin
                ftype_nxt = sv;
                sel_nxt   = 3'd4;
              end
              3'd4: begin
                fpos_nxt = sv;
                sel_nxt  = 3'd5;
              end
              3'd5: begin
                url_nxt     = UL_W'(sv);
                url_bad_nxt = (sv == '0) || (sv >= 32'(URL_LIMIT));
                sel_nxt     = 3'd6;
              end
              default: begin
                title_nxt     = TL_W'(sv);
                title_c       = CW'(TL_W'(sv));
                // Entry checks in order of priority.
                priority if (url_bad_r) begin
                  de_nxt    = ST_URL_LEN;
                  phase_nxt = PH_SKIP;
                end else if (sv >= 32'(TITLE_LIMIT)) begin
                  de_nxt    = ST_TITLE_LEN;
                  phase_nxt = PH_SKIP;
                end else if (url_c > left_c || title_c > left_c - url_c) begin
                  de_nxt    = ST_MISMATCH;
                  phase_nxt = PH_SKIP;
                end else if (scroll_r[31]) begin
                  de_nxt    = ST_SCROLL;
                  phase_nxt = PH_SKIP;
                end else begin
                  item_v              = 1'b1;
                  item.kind           = KIND_ENTRY;
                  item.entry_number   = 4'(ecnt_r);
                  item.scroll_offset  = scroll_r[30:0];
                  item.focus_type     = ftype_r;
                  item.focus_position = fpos_r;
                  item.url_bytes      = 11'(url_r);
                  item.title_bytes    = 8'(TL_W'(sv));
                  remain_nxt          = RW'(url_r);
                  phase_nxt           = PH_URL;
                end
              end
            endcase
          end
        end
        PH_URL: begin
          if (remain_r == RW'(url_r) && file_byte == 8'd0) begin
            de_nxt    = ST_NUL_URL;
            phase_nxt = PH_SKIP;
          end else begin
            item_v            = 1'b1;
            item.kind         = KIND_URL;
            item.data_byte    = file_byte;
            item.entry_number = 4'(ecnt_r);
            remain_nxt        = remain_r - RW'(1);
            if (remain_r == RW'(1)) begin
              if (title_r != '0) begin
                remain_nxt = RW'(title_r);
                phase_nxt  = PH_TITLE;
              end else begin
                ent_done = 1'b1;
              end
            end
          end
        end
        PH_TITLE: begin
          item_v            = 1'b1;
          item.kind         = KIND_TITLE;
          item.data_byte    = file_byte;
          item.entry_number = 4'(ecnt_r);
          remain_nxt        = remain_r - RW'(1);
          if (remain_r == RW'(1)) begin
            ent_done = 1'b1;
          end
        end
        PH_TAIL: begin
          de_nxt    = ST_MISMATCH;
          phase_nxt = PH_SKIP;
        end
        default: begin
        end
      endcase

      // Entry finished: next entry or the end of the history.
      if (ent_done) begin
        ecnt_nxt = ecnt_r + HD_W'(1);
        if (ecnt_r + HD_W'(1) >= total_r) begin
          phase_nxt = PH_TAIL;
        end else begin
          phase_nxt = PH_FIELDS;
          sel_nxt   = 3'd2;
        end
      end

      // End of the declared payload.
      if (ppos_nxt >= declared_r) begin
        if (phase_nxt != PH_TAIL && phase_nxt != PH_SKIP) begin
          de_nxt = ST_MISMATCH;
        end
        phase_nxt = PH_AFTER;
      end
    end

    // Verdict on the last byte; file errors come first.
    priority if (phase_nxt == PH_DISCARD) begin
      st = fe_nxt;
    end else if (phase_nxt != PH_AFTER) begin
      st = ST_SHORT;
    end else if (fe_nxt != ST_OK) begin
      st = fe_nxt;
    end else if (hash_nxt != expected_nxt) begin
      st = ST_CHECKSUM;
    end else begin
      st = de_nxt;
    end
    verdict.kind     = (st == ST_OK) ? KIND_ACCEPT : KIND_REJECT;
    verdict.status   = st;
    verdict.run_last = 1'b1;
    item.run_last    = !end_of_file;

    dec = '0;
    if (accept) begin
      unique case ({item_v, end_of_file})
        2'b11: begin
          dec.count = 2'd2;
          dec.r0    = item;
          dec.r1    = verdict;
        end
        2'b10: begin
          dec.count = 2'd1;
          dec.r0    = item;
        end
        2'b01: begin
          dec.count = 2'd1;
          dec.r0    = verdict;
        end
        default: begin
          dec.count = 2'd0;
        end
      endcase
    end

    // A file ends with the state back at its start.
    if (end_of_file) begin
      phase_nxt    = PH_HEADER;
      hpos_nxt     = '0;
      ppos_nxt     = '0;
      shift_nxt    = '0;
      fcnt_nxt     = '0;
      hash_nxt     = FNV_BASIS;
      declared_nxt = '0;
      len_big_nxt  = 1'b0;
      expected_nxt = '0;
      total_nxt    = '0;
      total_big_nxt = 1'b0;
      ecnt_nxt     = '0;
      sel_nxt      = '0;
      remain_nxt   = '0;
      fe_nxt       = ST_OK;
      de_nxt       = ST_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hpos_r      <= '0;
      ppos_r      <= '0;
      shift_r     <= '0;
      fcnt_r      <= '0;
      hash_r      <= FNV_BASIS;
      declared_r  <= '0;
      len_big_r   <= 1'b0;
      expected_r  <= '0;
      total_r     <= '0;
      total_big_r <= 1'b0;
      ecnt_r      <= '0;
      sel_r       <= '0;
      remain_r    <= '0;
      fe_r        <= ST_OK;
      de_r        <= ST_OK;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hpos_r      <= hpos_nxt;
      ppos_r      <= ppos_nxt;
      shift_r     <= shift_nxt;
      fcnt_r      <= fcnt_nxt;
      hash_r      <= hash_nxt;
      declared_r  <= declared_nxt;
      len_big_r   <= len_big_nxt;
      expected_r  <= expected_nxt;
      total_r     <= total_nxt;
      total_big_r <= total_big_nxt;
      ecnt_r      <= ecnt_nxt;
      sel_r       <= sel_nxt;
      remain_r    <= remain_nxt;
      fe_r        <= fe_nxt;
      de_r        <= de_nxt;
    end
  end

  // Held entry fields, only read after they are written.
  always_ff @(posedge clk) begin
    if (accept) begin
      scroll_r    <= scroll_nxt;
      ftype_r     <= ftype_nxt;
      fpos_r      <= fpos_nxt;
      url_r       <= url_nxt;
      url_bad_r   <= url_bad_nxt;
      title_r     <= title_nxt;
    end
  end

endmodule

// ===== hdl/tssp_out_queue.sv =====
// ----------------------------------------------------------------------------
// tssp_out_queue
// Small result queue: takes up to two items per cycle, hands out one.
// It reports room while two free slots remain.
// ----------------------------------------------------------------------------
module tssp_out_queue
  import tssp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dec_out_t wr,
  input  logic     rd,
  output res_t     head,
  output q_stat_t  stat
);

  res_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign pop       = rd && (cnt_r != '0);
  assign head      = mem_r[rp_r];
  assign stat.fill = cnt_r;
  assign stat.room = cnt_r <= Q_CW'(Q_DEPTH - 2);

  // Pointer and fill update.
  always_comb begin
    wp_nxt  = wp_r + Q_AW'(wr.count);
    rp_nxt  = rp_r + Q_AW'(pop);
    cnt_nxt = cnt_r + Q_CW'(wr.count) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem_r[wp_r] <= wr.r0;
    end
    if (wr.count == 2'd2) begin
      mem_r[wp_r + Q_AW'(1)] <= wr.r1;
    end
  end

endmodule

// ===== hdl/tab_snapshot_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// tab_snapshot_stream_parser_core
// Checks and decodes a tab hibernation file given one byte per item and emits
// snapshot and entry headers, url and title bytes and a final verdict.
//
//   channel | dir | tdata                      | tuser     | tlast
//   in_     | in  | file_byte                  | -         | end_of_file
//   out_    | out | result fields, see below   | item_kind | run_last
//
// One byte is taken per cycle; its results are written into the output
// queue at the accepting edge and are offered from the next cycle, one per
// cycle. The decoder computes its next state combinationally, so throughput is one
// byte per cycle. The final byte can yield two results; the queue absorbs
// the extra one, so input stalls only while the output is stalled.
// Reset is synchronous and active low; it empties the queue and restarts
// parsing at the magic. A stalled output holds in the queue.
// ----------------------------------------------------------------------------
module tab_snapshot_stream_parser_core
  import tssp_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned URL_LIMIT     = URL_LIMIT_DEF,
  parameter int unsigned TITLE_LIMIT   = TITLE_LIMIT_DEF,
  parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // file_byte
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // data_byte, entry_number, snap_entries, current_entry, scroll_offset,
  // focus_type, focus_position, url_bytes, title_bytes, status, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,  // item_kind
  output logic                  out_tlast
);

  dec_out_t dec;
  res_t     head;
  q_stat_t  qs;
  logic     in_acc;

  assign in_tready = qs.room;
  assign in_acc    = in_tvalid && in_tready;

  tssp_decoder #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .URL_LIMIT     (URL_LIMIT),
    .TITLE_LIMIT   (TITLE_LIMIT),
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .file_byte   (in_tdata),
    .end_of_file (in_tlast),
    .dec         (dec)
  );

  tssp_out_queue u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (dec),
    .rd    (out_tready),
    .head  (head),
    .stat  (qs)
  );

  // Output packing, first field in the lowest bits.
  assign out_tvalid = qs.fill != '0;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_last;
  assign out_tdata  = {5'd0, head.status, head.title_bytes, head.url_bytes,
                       head.focus_position, head.focus_type, head.scroll_offset,
                       head.current_entry, head.snap_entries, head.entry_number,
                       head.data_byte};

  // The queue never overfills.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qs.fill <= Q_CW'(Q_DEPTH))
    else $error("output queue overfilled");

  // A final byte always leaves a verdict behind.
  a_verdict_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid)
    else $error("no result after final byte");

  // A second result in one cycle is always the verdict.
  a_second_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    dec.count == 2'd2 |-> (dec.r1.kind == KIND_ACCEPT || dec.r1.kind == KIND_REJECT))
    else $error("second result is not a verdict");

endmodule
